// ===== src/adrf_pkg.sv =====
// Package for the audio/data expansion register file.
// Holds request and result types, request codes, register numbers and the identifier table.
// No dependencies.
`default_nettype none
package adrf_pkg;

  localparam int unsigned ADRF_REVISION = 2;

  typedef enum logic [2:0] {
    REQ_READ        = 3'd0,
    REQ_WRITE       = 3'd1,
    REQ_TRACK_READY = 3'd2,
    REQ_TRACK_FAIL  = 3'd3,
    REQ_PLAY_END    = 3'd4,
    REQ_SOFT_RESET  = 3'd5
  } req_kind_t;

  localparam logic [2:0] REG_SEEK0   = 3'd0;
  localparam logic [2:0] REG_SEEK1   = 3'd1;
  localparam logic [2:0] REG_SEEK2   = 3'd2;
  localparam logic [2:0] REG_SEEK3   = 3'd3;
  localparam logic [2:0] REG_TRACK0  = 3'd4;
  localparam logic [2:0] REG_TRACK1  = 3'd5;
  localparam logic [2:0] REG_VOLUME  = 3'd6;
  localparam logic [2:0] REG_CONTROL = 3'd7;

  localparam logic [2:0] REG_STATUS  = 3'd0;
  localparam logic [2:0] REG_DATA    = 3'd1;

  localparam logic [7:0] STAT_BUSY    = 8'h40;
  localparam logic [7:0] STAT_REPEAT  = 8'h20;
  localparam logic [7:0] STAT_PLAYING = 8'h10;
  localparam logic [7:0] STAT_MISSING = 8'h08;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_byte;
    logic [7:0] fetched_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [31:0] data_address;
    logic [7:0]  volume_level;
    logic [15:0] track_number;
    logic        track_request;
    logic        busy_flag;
    logic        playing_flag;
    logic        repeat_flag;
    logic        missing_flag;
  } rsp_t;

  typedef struct packed {
    logic item_valid;
    logic take;
  } stage_ctl_t;

  function automatic logic [7:0] ident_char(input logic [2:0] reg_index);
    logic [7:0] c;
    case (reg_index)
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h2d;
      3'd4:    c = 8'h4d;
      3'd5:    c = 8'h53;
      3'd6:    c = 8'h55;
      3'd7:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/adrf_req_if.sv =====
// Request channel interface: valid/ready handshake plus request fields.
// Standalone; no package dependency.
`default_nettype none
interface adrf_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [2:0] reg_index;
  logic [7:0] write_byte;
  logic [7:0] fetched_byte;

  modport source (output valid, req_type, reg_index, write_byte, fetched_byte, input ready);
  modport sink   (input valid, req_type, reg_index, write_byte, fetched_byte, output ready);
endinterface
`default_nettype wire

// ===== src/adrf_rsp_if.sv =====
// Result channel interface: valid/ready handshake plus result fields.
// Standalone; no package dependency.
`default_nettype none
interface adrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [31:0] data_address;
  logic [7:0]  volume_level;
  logic [15:0] track_number;
  logic        track_request;
  logic        busy_flag;
  logic        playing_flag;
  logic        repeat_flag;
  logic        missing_flag;

  modport source (output valid, read_data, data_address, volume_level, track_number,
                  track_request, busy_flag, playing_flag, repeat_flag, missing_flag,
                  input ready);
  modport sink   (input valid, read_data, data_address, volume_level, track_number,
                  track_request, busy_flag, playing_flag, repeat_flag, missing_flag,
                  output ready);
endinterface
`default_nettype wire

// ===== src/audio_data_expansion_register_file_core.sv =====
// Top level of the audio/data expansion register file.
// Depends on adrf_pkg, adrf_req_if, adrf_rsp_if, adrf_in_stage, adrf_regs, adrf_out_stage.
//
// Usage:
//   req  : request channel (valid/ready). Each transaction is a bus read or write of one of
//          eight registers, a back-end event (track ready, track failed, playback ended) or
//          a soft reset. fetched_byte carries the data track byte at the current pointer.
//   rsp  : result channel (valid/ready). Exactly one result transaction per request, in order.
//   cfg  : cfg_we/cfg_wdata write the data track size; write only while idle.
// Path: a request accepted into the input register goes through the update logic into the
// result register, from which rsp offers it.
// Throughput: one transaction per cycle unless rsp stalls; the state update is a single pass
// from the input register to the result register, so back-to-back requests need no bubbles.
// Reset: rst (synchronous) empties both registers and clears all state and the track size.
// Stall: while rsp is held, the pending result stays in the result register, one more request
// is still taken into the input register, and then req.ready drops until rsp drains.
`default_nettype none
module audio_data_expansion_register_file_core #(
  parameter int unsigned REVISION = adrf_pkg::ADRF_REVISION
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  adrf_req_if.sink         req,
  adrf_rsp_if.source       rsp
);
  import adrf_pkg::*;

  req_t       item;
  rsp_t       rsp_next;
  stage_ctl_t ctl;

  adrf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (ctl.take),
    .item_valid (ctl.item_valid),
    .item       (item)
  );

  adrf_regs #(
    .REVISION (REVISION)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .item      (item),
    .rsp_next  (rsp_next)
  );

  adrf_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rsp_next (rsp_next),
    .take     (ctl.take),
    .rsp      (rsp)
  );
endmodule
`default_nettype wire

// ===== src/adrf_in_stage.sv =====
// Input register for request transactions.
// Depends on adrf_pkg and adrf_req_if.
`default_nettype none
module adrf_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  adrf_req_if.sink           req,
  input  wire logic          take,
  output logic               item_valid,
  output adrf_pkg::req_t     item
);
  import adrf_pkg::*;

  assign req.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item.req_type     <= req.req_type;
      item.reg_index    <= req.reg_index;
      item.write_byte   <= req.write_byte;
      item.fetched_byte <= req.fetched_byte;
    end
  end
endmodule
`default_nettype wire

// ===== src/adrf_regs.sv =====
// Register file state and per-transaction update logic.
// Depends on adrf_pkg.
`default_nettype none
module adrf_regs #(
  parameter int unsigned REVISION = adrf_pkg::ADRF_REVISION
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire adrf_pkg::stage_ctl_t ctl,
  input  wire adrf_pkg::req_t    item,
  output adrf_pkg::rsp_t         rsp_next
);
  import adrf_pkg::*;

  logic [31:0] track_size;
  logic [31:0] seek, seek_next;
  logic [15:0] track_asm, track_asm_next;
  logic [15:0] req_track, req_track_next;
  logic [7:0]  volume, volume_next;
  logic [31:0] pointer, pointer_next;
  logic        busy, busy_next;
  logic        playing, playing_next;
  logic        rpt, rpt_next;
  logic        missing, missing_next;
  logic        opened, opened_next;
  logic [7:0]  rdata;
  logic        treq;
  logic        step;
  logic [7:0]  status;

  assign step = ctl.item_valid && ctl.take;

  always_comb begin
    status = {5'b0, 3'(REVISION)};
    if (busy)    status = status | STAT_BUSY;
    if (rpt)     status = status | STAT_REPEAT;
    if (playing) status = status | STAT_PLAYING;
    if (missing) status = status | STAT_MISSING;
  end

  always_comb begin
    seek_next      = seek;
    track_asm_next = track_asm;
    req_track_next = req_track;
    volume_next    = volume;
    pointer_next   = pointer;
    busy_next      = busy;
    playing_next   = playing;
    rpt_next       = rpt;
    missing_next   = missing;
    opened_next    = opened;
    rdata          = 8'h00;
    treq           = 1'b0;
    unique case (req_kind_t'(item.req_type))
      REQ_READ: begin
        if (item.reg_index == REG_STATUS) begin
          rdata = status;
        end else if (item.reg_index == REG_DATA) begin
          rdata        = (pointer < track_size) ? item.fetched_byte : 8'h00;
          pointer_next = pointer + 32'd1;
        end else begin
          rdata = ident_char(item.reg_index);
        end
      end
      REQ_WRITE: begin
        unique case (item.reg_index)
          REG_SEEK0: seek_next[7:0]   = item.write_byte;
          REG_SEEK1: seek_next[15:8]  = item.write_byte;
          REG_SEEK2: seek_next[23:16] = item.write_byte;
          REG_SEEK3: begin
            seek_next[31:24] = item.write_byte;
            pointer_next     = {item.write_byte, seek[23:0]};
          end
          REG_TRACK0: track_asm_next[7:0] = item.write_byte;
          REG_TRACK1: begin
            track_asm_next[15:8] = item.write_byte;
            req_track_next       = {item.write_byte, track_asm[7:0]};
            playing_next         = 1'b0;
            rpt_next             = 1'b0;
            missing_next         = 1'b0;
            opened_next          = 1'b0;
            busy_next            = 1'b1;
            treq                 = 1'b1;
          end
          REG_VOLUME: volume_next = item.write_byte;
          REG_CONTROL: begin
            if (!busy && !missing && opened) begin
              rpt_next     = item.write_byte[1];
              playing_next = item.write_byte[0];
            end
          end
          default: ;
        endcase
      end
      REQ_TRACK_READY: begin
        if (busy) begin
          opened_next = 1'b1;
          busy_next   = 1'b0;
        end
      end
      REQ_TRACK_FAIL: begin
        if (busy) begin
          missing_next = 1'b1;
          opened_next  = 1'b0;
          busy_next    = 1'b0;
        end
      end
      REQ_PLAY_END: playing_next = 1'b0;
      REQ_SOFT_RESET: begin
        seek_next      = '0;
        track_asm_next = '0;
        volume_next    = '0;
        pointer_next   = '0;
        busy_next      = 1'b0;
        playing_next   = 1'b0;
        rpt_next       = 1'b0;
        missing_next   = 1'b0;
        opened_next    = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_next.read_data     = rdata;
    rsp_next.data_address  = ((req_kind_t'(item.req_type) == REQ_READ) &&
                              (item.reg_index == REG_DATA)) ? pointer : pointer_next;
    rsp_next.volume_level  = volume_next;
    rsp_next.track_number  = req_track_next;
    rsp_next.track_request = treq;
    rsp_next.busy_flag     = busy_next;
    rsp_next.playing_flag  = playing_next;
    rsp_next.repeat_flag   = rpt_next;
    rsp_next.missing_flag  = missing_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_size <= '0;
    end else if (cfg_we) begin
      track_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seek      <= '0;
      track_asm <= '0;
      req_track <= '0;
      volume    <= '0;
      pointer   <= '0;
      busy      <= 1'b0;
      playing   <= 1'b0;
      rpt       <= 1'b0;
      missing   <= 1'b0;
      opened    <= 1'b0;
    end else if (step) begin
      seek      <= seek_next;
      track_asm <= track_asm_next;
      req_track <= req_track_next;
      volume    <= volume_next;
      pointer   <= pointer_next;
      busy      <= busy_next;
      playing   <= playing_next;
      rpt       <= rpt_next;
      missing   <= missing_next;
      opened    <= opened_next;
    end
  end
endmodule
`default_nettype wire

// ===== src/adrf_out_stage.sv =====
// Result register driving the result channel.
// Depends on adrf_pkg and adrf_rsp_if.
`default_nettype none
module adrf_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire adrf_pkg::stage_ctl_t ctl,
  input  wire adrf_pkg::rsp_t       rsp_next,
  output logic                      take,
  adrf_rsp_if.source                rsp
);
  import adrf_pkg::*;

  rsp_t result;

  assign take = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= ctl.item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.item_valid) begin
      result <= rsp_next;
    end
  end

  assign rsp.read_data     = result.read_data;
  assign rsp.data_address  = result.data_address;
  assign rsp.volume_level  = result.volume_level;
  assign rsp.track_number  = result.track_number;
  assign rsp.track_request = result.track_request;
  assign rsp.busy_flag     = result.busy_flag;
  assign rsp.playing_flag  = result.playing_flag;
  assign rsp.repeat_flag   = result.repeat_flag;
  assign rsp.missing_flag  = result.missing_flag;
endmodule
`default_nettype wire
